@@ rtl/qps_pkg.sv @@
// Shared types, constants and helpers for the quadrature PID position servo.
// No dependencies; every other file in rtl/ imports this package.
package qps_pkg;

    localparam int COUNT_W    = 48;
    localparam int POS_W      = 48;
    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 16;
    localparam int DUTY_W     = 16;
    localparam int DRIVE_W    = 48;
    localparam int ERR_W      = 32;
    localparam int DELTA_W    = 32;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_MOVE   = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_INTEG_GAIN   = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_INTEG_WINDOW = 3'd3,
        CFG_DONE_BAND    = 3'd4,
        CFG_DIR_POLARITY = 3'd5
    } cfg_idx_t;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 24'd33554;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 24'd168;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 24'd838861;
    localparam logic [LIMIT_W-1:0] INTEG_WINDOW_RST = 16'd50;
    localparam logic [LIMIT_W-1:0] DONE_BAND_RST    = 16'd1;

    // Count change for {prev_a, prev_b, a, b}
    localparam logic signed [1:0] QUAD_STEP [16] = '{
        2'sb00, 2'sb11, 2'sb01, 2'sb00,
        2'sb01, 2'sb00, 2'sb00, 2'sb11,
        2'sb11, 2'sb00, 2'sb00, 2'sb01,
        2'sb00, 2'sb01, 2'sb11, 2'sb00
    };

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LIMIT_W-1:0] integrate_window;
        logic [LIMIT_W-1:0] done_band;
        logic               dir_polarity;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic move;
    } pid_ctl_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              direction;
        logic              busy;
    } pid_stat_t;

    // Clamp a 64-bit signed sum to the signed 48-bit range
    function automatic logic signed [DRIVE_W-1:0] sat_drive(input logic signed [ACC_W-1:0] v);
        logic hi_zero;
        logic hi_ones;
        begin
            hi_zero = (v[ACC_W-1:DRIVE_W-1] == '0);
            hi_ones = (v[ACC_W-1:DRIVE_W-1] == '1);
            if (hi_zero || hi_ones)
            begin
                sat_drive = v[DRIVE_W-1:0];
            end
            else if (v[ACC_W-1])
            begin
                sat_drive = {1'b1, {(DRIVE_W-1){1'b0}}};
            end
            else
            begin
                sat_drive = {1'b0, {(DRIVE_W-1){1'b1}}};
            end
        end
    endfunction

endpackage

@@ rtl/qps_if.sv @@
// Valid/ready channel interfaces for item, result and configuration words.
// Depends on qps_pkg.
interface qps_item_if;
    import qps_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic                      pin_a;
    logic                      pin_b;
    logic signed [DELTA_W-1:0] move_delta;
    modport source (output valid, operation, pin_a, pin_b, move_delta, input ready);
    modport sink   (input valid, operation, pin_a, pin_b, move_delta, output ready);
endinterface

interface qps_result_if;
    import qps_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [DUTY_W-1:0]       duty;
    logic                    direction;
    logic                    busy_res;
    logic signed [POS_W-1:0] position;
    modport source (output valid, duty, direction, busy_res, position, input ready);
    modport sink   (input valid, duty, direction, busy_res, position, output ready);
endinterface

interface qps_cfg_if;
    import qps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/qps_quad.sv @@
// Quadrature decoder: previous pin levels and the position counter.
// Depends on qps_pkg.
module qps_quad
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        sample_en,
    input  logic                        pin_a,
    input  logic                        pin_b,
    output logic [qps_pkg::COUNT_W-1:0] count,
    output logic [qps_pkg::COUNT_W-1:0] count_next
);
    import qps_pkg::*;

    logic [1:0]         prev_reg;
    logic [1:0]         prev_next;
    logic [COUNT_W-1:0] count_reg;
    logic signed [1:0]  step;

    always_comb
    begin
        step       = QUAD_STEP[{prev_reg, pin_a, pin_b}];
        prev_next  = prev_reg;
        count_next = count_reg;
        if (sample_en)
        begin
            prev_next = {pin_a, pin_b};
            if (step == 2'sb01)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            else if (step == 2'sb11)
            begin
                count_next = count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

@@ rtl/qps_pid.sv @@
// Move setpoint, PID loop state and duty/direction computation.
// Depends on qps_pkg.
module qps_pid
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  qps_pkg::pid_ctl_t                  ctl,
    input  qps_pkg::cfg_t                      cfg,
    input  logic signed [qps_pkg::DELTA_W-1:0] move_delta,
    input  logic [qps_pkg::COUNT_W-1:0]        count,
    output qps_pkg::pid_stat_t                 stat
);
    import qps_pkg::*;

    logic [COUNT_W-1:0]        setpoint_reg, setpoint_next;
    logic                      moving_reg, moving_next;
    logic signed [ERR_W-1:0]   last_err_reg, last_err_next;
    logic signed [DRIVE_W-1:0] integ_reg, integ_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;

    logic signed [COUNT_W-1:0]     diff;
    logic signed [ERR_W-1:0]       err;
    logic signed [ERR_W:0]         err_x;
    logic [ERR_W:0]                aerr;
    logic signed [ERR_W:0]         d_diff;
    logic signed [GAIN_W+ERR_W:0]  p_prod;
    logic signed [GAIN_W+ERR_W:0]  i_prod;
    logic signed [GAIN_W+ERR_W+1:0] d_prod;
    logic signed [ACC_W-1:0]       integ_sum;
    logic signed [DRIVE_W-1:0]     integ_new;
    logic signed [ACC_W-1:0]       acc;
    logic signed [DRIVE_W-1:0]     drive_sat;
    logic                          in_window;
    logic                          done;
    logic                          dir_bit;
    logic [DRIVE_W-1:0]            mag;
    logic [GAIN_W+DUTY_W-1:0]      scaled;
    logic [DUTY_W-1:0]             duty;

    // Error, saturated to 32 bits
    always_comb
    begin
        diff = setpoint_reg - count;
        if ((diff[COUNT_W-1:ERR_W-1] == '0) || (diff[COUNT_W-1:ERR_W-1] == '1))
        begin
            err = diff[ERR_W-1:0];
        end
        else if (diff[COUNT_W-1])
        begin
            err = {1'b1, {(ERR_W-1){1'b0}}};
        end
        else
        begin
            err = {1'b0, {(ERR_W-1){1'b1}}};
        end
        err_x = {err[ERR_W-1], err};
        aerr  = err_x[ERR_W] ? (ERR_W+1)'(-err_x) : (ERR_W+1)'(err_x);
    end

    // Gain products and the loop sum
    always_comb
    begin
        d_diff    = err_x - {last_err_reg[ERR_W-1], last_err_reg};
        p_prod    = $signed({1'b0, cfg.prop_gain}) * err;
        i_prod    = $signed({1'b0, cfg.integ_gain}) * err;
        d_prod    = $signed({1'b0, cfg.deriv_gain}) * d_diff;
        in_window = (err != '0) && (aerr <= (ERR_W+1)'(cfg.integrate_window));
        integ_sum = ACC_W'(integ_reg) + ACC_W'(i_prod);
        integ_new = in_window ? sat_drive(integ_sum) : '0;
        acc       = ACC_W'(p_prod) + ACC_W'(d_prod) + ACC_W'(integ_new);
        drive_sat = sat_drive(acc);
        done      = aerr <= (ERR_W+1)'(cfg.done_band);
        if (cfg.dir_polarity)
        begin
            dir_bit = drive_sat[DRIVE_W-1];
        end
        else
        begin
            dir_bit = !drive_sat[DRIVE_W-1] && (drive_sat != '0);
        end
    end

    // Duty from the drive held before this tick: |drive| * 65535 / 2^24
    always_comb
    begin
        mag    = drive_reg[DRIVE_W-1] ? DRIVE_W'(-drive_reg) : DRIVE_W'(drive_reg);
        scaled = {mag[GAIN_W-1:0], {DUTY_W{1'b0}}} - (GAIN_W+DUTY_W)'(mag[GAIN_W-1:0]);
        if (mag[DRIVE_W-1:GAIN_W] != '0)
        begin
            duty = '1;
        end
        else
        begin
            duty = scaled[GAIN_W+DUTY_W-1:GAIN_W];
        end
    end

    always_comb
    begin
        setpoint_next = setpoint_reg;
        moving_next   = moving_reg;
        last_err_next = last_err_reg;
        integ_next    = integ_reg;
        drive_next    = drive_reg;
        if (ctl.move)
        begin
            setpoint_next = count + COUNT_W'(move_delta);
            moving_next   = 1'b1;
        end
        else if (ctl.tick)
        begin
            last_err_next = err;
            integ_next    = integ_new;
            drive_next    = done ? '0 : drive_sat;
            moving_next   = done ? 1'b0 : moving_reg;
        end
    end

    always_comb
    begin
        stat.duty      = ctl.tick ? duty : '0;
        stat.direction = ctl.tick ? dir_bit : 1'b0;
        stat.busy      = moving_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg <= '0;
            moving_reg   <= 1'b0;
            last_err_reg <= '0;
            integ_reg    <= '0;
            drive_reg    <= '0;
        end
        else
        begin
            setpoint_reg <= setpoint_next;
            moving_reg   <= moving_next;
            last_err_reg <= last_err_next;
            integ_reg    <= integ_next;
            drive_reg    <= drive_next;
        end
    end

endmodule

@@ rtl/quadrature_pid_position_servo.sv @@
// Top level of the quadrature PID position servo: channel registers and
// configuration registers. Depends on qps_pkg, qps_if, qps_quad, qps_pid.
//
// Usage:
//   item   - input words: encoder sample (pin_a, pin_b), control tick, or
//            start move (move_delta). Every word yields exactly one result.
//   result - duty and direction (nonzero on ticks only), busy_res and the
//            position count after the word.
//   cfg    - register writes (index, data), always ready; write only while
//            no word is in flight.
// Path: a word accepted on item is registered in the input register, processed
//   from there and its result is registered in the result register.
// Throughput: one word per cycle while result is taken. The rate is set by the
//   state update loop (position counter and PID state).
// Stall: while result is not taken the input register holds its word and
//   item.ready drops once that register is full; nothing is lost.
// Reset: rst_n clears position, setpoint, PID state and the channel valid
//   flags, and loads the default gains, window, band and polarity.
module quadrature_pid_position_servo
(
    input logic         clk,
    input logic         rst_n,
    qps_item_if.sink    item,
    qps_result_if.source result,
    qps_cfg_if.sink     cfg
);
    import qps_pkg::*;

    // Input register
    logic                      in_valid_reg, in_valid_next;
    logic [1:0]                op_reg;
    logic                      pin_a_reg;
    logic                      pin_b_reg;
    logic signed [DELTA_W-1:0] delta_reg;

    // Result register
    logic                      out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]         duty_reg;
    logic                      dir_reg;
    logic                      busy_reg;
    logic signed [POS_W-1:0]   pos_reg;

    cfg_t                      cfg_reg, cfg_next;

    logic                      advance;
    logic                      load;
    pid_ctl_t                  pid_ctl;
    pid_stat_t                 pid_stat;
    logic [COUNT_W-1:0]        count;
    logic [COUNT_W-1:0]        count_next;
    logic                      sample_en;

    // Process the held word whenever the result register is free or drains
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign load       = item.valid && item.ready;

    assign sample_en    = advance && (op_reg == OP_SAMPLE);
    assign pid_ctl.tick = advance && (op_reg == OP_TICK);
    assign pid_ctl.move = advance && (op_reg == OP_MOVE);

    qps_quad u_quad
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_en  (sample_en),
        .pin_a      (pin_a_reg),
        .pin_b      (pin_b_reg),
        .count      (count),
        .count_next (count_next)
    );

    qps_pid u_pid
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (pid_ctl),
        .cfg        (cfg_reg),
        .move_delta (delta_reg),
        .count      (count),
        .stat       (pid_stat)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (load)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration decode; unknown indexes are dropped
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_PROP_GAIN:    cfg_next.prop_gain        = cfg.data[GAIN_W-1:0];
                CFG_INTEG_GAIN:   cfg_next.integ_gain       = cfg.data[GAIN_W-1:0];
                CFG_DERIV_GAIN:   cfg_next.deriv_gain       = cfg.data[GAIN_W-1:0];
                CFG_INTEG_WINDOW: cfg_next.integrate_window = cfg.data[LIMIT_W-1:0];
                CFG_DONE_BAND:    cfg_next.done_band        = cfg.data[LIMIT_W-1:0];
                CFG_DIR_POLARITY: cfg_next.dir_polarity     = cfg.data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
            cfg_reg.prop_gain         <= PROP_GAIN_RST;
            cfg_reg.integ_gain        <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain        <= DERIV_GAIN_RST;
            cfg_reg.integrate_window  <= INTEG_WINDOW_RST;
            cfg_reg.done_band         <= DONE_BAND_RST;
            cfg_reg.dir_polarity      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    // Payload registers: capture on load / advance only
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg    <= item.operation;
            pin_a_reg <= item.pin_a;
            pin_b_reg <= item.pin_b;
            delta_reg <= item.move_delta;
        end
        if (advance)
        begin
            duty_reg <= pid_stat.duty;
            dir_reg  <= pid_stat.direction;
            busy_reg <= pid_stat.busy;
            pos_reg  <= POS_W'($signed(count_next));
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.duty      = duty_reg;
    assign result.direction = dir_reg;
    assign result.busy_res  = busy_reg;
    assign result.position  = pos_reg;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for quadrature_pid_position_servo: encoder decode, moves and PID ticks.
// Depends on qps_pkg, the qps_if channel interfaces and the RTL under rtl/.
module tb;
    import qps_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 2;
    localparam int DRAIN_CYCLES = 8;     // time for the last results to come back; leave margin
    localparam int STALL_LIMIT  = 2000;  // cycles with no handshake on any channel

    // Codes the package enums leave out; the fields still carry them
    localparam logic [1:0]           OP_SPARE  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // Power-on register values
    localparam logic [23:0] KP_RESET   = 24'd33554;
    localparam logic [23:0] KI_RESET   = 24'd168;
    localparam logic [23:0] KD_RESET   = 24'd838861;
    localparam logic [15:0] WIN_RESET  = 16'd50;
    localparam logic [15:0] BAND_RESET = 16'd1;

    localparam longint S48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint S48_LO = -64'sh0000_8000_0000_0000;
    localparam longint S32_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_LO = -64'sh0000_0000_8000_0000;
    localparam longint Q_UNIT = 64'sh0000_0000_0100_0000;

    typedef enum int { SET_TYPICAL, SET_ALL_MAX, SET_ALL_ZERO } gain_set_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              direction;
        logic              busy;
        logic [POS_W-1:0]  position;
    } servo_result_t;

    logic clk = 1'b0;
    logic rst_n;

    qps_item_if   word_in ();
    qps_result_if word_out ();
    qps_cfg_if    cfg_bus ();

    quadrature_pid_position_servo i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (word_in),
        .result (word_out),
        .cfg    (cfg_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Servo state as the testbench tracks it
    // ------------------------------------------------------------------
    logic [1:0]         pin_state;   // {A, B} from the last sample word
    logic [COUNT_W-1:0] count_q;
    logic [COUNT_W-1:0] target_q;
    logic signed [31:0] err_prev;
    logic signed [47:0] integ_acc;
    logic signed [47:0] drive_q;
    logic               moving_q;

    logic [23:0] kp, ki, kd;
    logic [15:0] win, band;
    logic        pol;

    servo_result_t expected_results[$];
    servo_result_t want;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int results_checked = 0;
    int reg_writes     = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    // Position of {A, B} along the Gray cycle 00 -> 10 -> 11 -> 01 (count up)
    function automatic logic [1:0] enc_phase(logic [1:0] ab);
        return {ab[0], ab[1] ^ ab[0]};
    endfunction

    function automatic logic signed [47:0] clamp48(longint v);
        if (v > S48_HI)
            return S48_HI[47:0];
        if (v < S48_LO)
            return S48_LO[47:0];
        return v[47:0];
    endfunction

    // Signed distance still to go, as the block sees it before any clamping
    function automatic longint servo_error();
        logic signed [47:0] gap;
        gap = target_q - count_q;
        return gap;
    endfunction

    task automatic servo_model_reset();
        pin_state = 2'b00;
        count_q   = '0;
        target_q  = '0;
        err_prev  = '0;
        integ_acc = '0;
        drive_q   = '0;
        moving_q  = 1'b0;
        kp   = KP_RESET;
        ki   = KI_RESET;
        kd   = KD_RESET;
        win  = WIN_RESET;
        band = BAND_RESET;
        pol  = 1'b0;
    endtask

    // Advance the tracked state by one accepted word and return its result
    function automatic servo_result_t servo_predict(logic [1:0] op, logic a, logic b,
                                                    logic signed [31:0] delta);
        servo_result_t r;
        logic [1:0]    moved;
        longint        mag, err, aerr, acc, dl, last_l;
        longint        kp_l, ki_l, kd_l, win_l, band_l;
        r = '0;
        case (op)
            OP_SAMPLE:
            begin
                // Gray step of +1 or -1 counts; a two-phase jump is illegal and counts nothing
                moved = enc_phase({a, b}) - enc_phase(pin_state);
                if (moved == 2'd1)
                    count_q = count_q + 1'b1;
                else if (moved == 2'd3)
                    count_q = count_q - 1'b1;
                pin_state = {a, b};
            end
            OP_MOVE:
            begin
                target_q = count_q + {{(COUNT_W - 32){delta[31]}}, delta};
                moving_q = 1'b1;
            end
            OP_TICK:
            begin
                kp_l = kp;
                ki_l = ki;
                kd_l = kd;
                win_l = win;
                band_l = band;
                dl = drive_q;
                mag = (dl < 0) ? -dl : dl;
                if (mag >= Q_UNIT)
                    r.duty = '1;
                else
                    r.duty = 16'((mag * 65535) >>> 24);

                err = servo_error();
                if (err > S32_HI)
                    err = S32_HI;
                if (err < S32_LO)
                    err = S32_LO;
                aerr = (err < 0) ? -err : err;

                acc = kp_l * err;
                if (err == 0 || aerr > win_l)
                    integ_acc = '0;
                else
                begin
                    integ_acc = clamp48(longint'(integ_acc) + ki_l * err);
                    acc = acc + integ_acc;
                end
                last_l = err_prev;
                acc = acc + kd_l * (err - last_l);
                err_prev = err[31:0];
                drive_q = clamp48(acc);

                if (pol)
                    r.direction = drive_q[47];
                else
                    r.direction = !drive_q[47] && (drive_q != '0);

                if (aerr <= band_l)
                begin
                    moving_q = 1'b0;
                    drive_q = '0;
                end
            end
            default:
            begin
            end
        endcase
        r.busy = moving_q;
        r.position = count_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Offer one word, hold it until taken, then log what it should produce.
    // Valid stays high afterwards so back-to-back words need no gap.
    task automatic send_word(logic [1:0] op, logic a, logic b, logic signed [31:0] delta);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            word_in.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        word_in.valid      <= 1'b1;
        word_in.operation  <= op;
        word_in.pin_a      <= a;
        word_in.pin_b      <= b;
        word_in.move_delta <= delta;
        do
            @(posedge clk);
        while (!word_in.ready);
        expected_results.push_back(servo_predict(op, a, b, delta));
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(OP_TICK, 1'($urandom), 1'($urandom), $urandom);
    endtask

    task automatic send_move(logic signed [31:0] delta);
        send_word(OP_MOVE, 1'($urandom), 1'($urandom), delta);
    endtask

    // Move the encoder by dir Gray phases: +1/-1 count, 0 repeats the pins, 2 is illegal
    task automatic step_encoder(int dir);
        logic [1:0] nxt;
        nxt = enc_phase(pin_state) + 2'(dir);
        send_word(OP_SAMPLE, nxt[0] ^ nxt[1], nxt[1], $urandom);
    endtask

    // Drop valid and wait until every result is back; the block is idle after that
    task automatic settle();
        word_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Write one register; keep valid up when more writes follow right away
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value,
                             logic more);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            CFG_PROP_GAIN:    kp = value;
            CFG_INTEG_GAIN:   ki = value;
            CFG_DERIV_GAIN:   kd = value;
            CFG_INTEG_WINDOW: win = value[15:0];
            CFG_DONE_BAND:    band = value[15:0];
            CFG_DIR_POLARITY: pol = value[0];
            default:
            begin
            end
        endcase
        reg_writes++;
        if (!more)
            cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_all_regs(logic [23:0] p, logic [23:0] i, logic [23:0] d,
                                  logic [23:0] w, logic [23:0] b, logic [23:0] pol_data);
        write_reg(CFG_PROP_GAIN, p, 1'b1);
        write_reg(CFG_INTEG_GAIN, i, 1'b1);
        write_reg(CFG_DERIV_GAIN, d, 1'b1);
        write_reg(CFG_INTEG_WINDOW, w, 1'b1);
        write_reg(CFG_DONE_BAND, b, 1'b1);
        write_reg(CFG_DIR_POLARITY, pol_data, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver pacing
    // ------------------------------------------------------------------
    function automatic void report_field(string what, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (word_out.valid && word_out.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result mismatch, expected none, actual duty %0d dir %0d",
                             $time, word_out.duty, word_out.direction);
                    $display("%0t:   actual busy %0d pos %0d",
                             $time, word_out.busy_res, word_out.position);
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    report_field("duty", want.duty, word_out.duty);
                    report_field("direction", want.direction, word_out.direction);
                    report_field("busy_res", want.busy, word_out.busy_res);
                    report_field("position", $signed(want.position), word_out.position);
                end
            end
        end
        // Hold ready low in reset, then stall at the rate this phase asks for
        word_out.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run if no channel moves a word for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((word_in.valid && word_in.ready) || (word_out.valid && word_out.ready)
                 || (cfg_bus.valid && cfg_bus.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("quadrature_pid_position_servo regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Decode: idle tick, full cycles both ways, illegal jumps, repeated pins, spare code
    task automatic test_quadrature_decode();
        send_tick();            // done band with no move: drive stays zero
        repeat (4)
            step_encoder(1);
        repeat (5)
            step_encoder(-1);
        step_encoder(2);
        step_encoder(2);
        step_encoder(0);
        send_word(OP_SPARE, 1'b1, 1'b1, 32'hFFFF_FFFF);
        settle();
    endtask

    // Short move, PID ticks while closing in, retarget mid-move, finish inside the band
    task automatic test_move_and_tick();
        send_move(32'sd5);
        send_tick();
        step_encoder(1);
        step_encoder(1);
        send_tick();
        send_move(-32'sd4);     // replace the target, keep PID state
        send_tick();
        repeat (3)
            step_encoder(-1);
        send_tick();            // error one count: move ends, drive cleared
        send_tick();
        settle();
    endtask

    // Largest deltas: error clamped to 32 bits, drive clamped to 48 bits, duty full scale,
    // then both polarities including a zero drive
    task automatic test_error_extremes();
        send_move(32'sh7FFF_FFFF);
        send_tick();
        step_encoder(-1);       // error one past the 32-bit top: clamps
        send_tick();
        send_move(32'sh8000_0000);
        send_tick();
        settle();
        write_reg(CFG_DIR_POLARITY, 24'd1, 1'b0);
        send_tick();
        send_move(32'sd0);
        send_tick();
        send_tick();            // zero drive: direction low even with inverted polarity
        settle();
        write_reg(CFG_DIR_POLARITY, 24'd0, 1'b0);
    endtask

    // Full integral gain at the window edge: drive the integrator into its upper clamp, then move past the window
    task automatic test_integral_clamp();
        write_all_regs(24'd0, 24'hFF_FFFF, 24'd0, 24'h00_FFFF, 24'd0, 24'd0);
        send_move(32'sd65535);
        repeat (140)
            send_tick();
        send_move(-32'sd131070);
        repeat (270)
            send_tick();
        settle();
    endtask

    // Random moves followed by a loosely tracking encoder, with some noise words mixed in
    task automatic test_random_servo(int idle_pct, int stall_pct, gain_set_t gains, int goal);
        int                 counted;
        int                 roll;
        int                 toward;
        logic [1:0]         op;
        logic signed [31:0] delta;
        longint             e;
        counted = 0;
        case (gains)
            SET_ALL_MAX:
                write_all_regs('1, '1, '1, '1, '1, '1);
            SET_ALL_ZERO:
                write_all_regs('0, '0, '0, '0, '0, '0);
            default:
            begin
                write_reg(CFG_SPARE, 24'($urandom), 1'b1);
                // Upper bits of the 16-bit registers carry junk the block must drop
                write_all_regs(24'($urandom_range(0, 1 << 20)), 24'($urandom_range(0, 4096)),
                               24'($urandom), {8'($urandom), 16'($urandom_range(0, 300))},
                               {8'($urandom), 16'($urandom_range(0, 8))}, 24'($urandom));
            end
        endcase
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (counted < goal)
        begin
            if ($urandom_range(99) < 10)
            begin
                op = 2'($urandom_range(3));
                send_word(op, 1'($urandom), 1'($urandom), $urandom);
                if (op != OP_SPARE)
                    counted++;
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 65)
                    delta = $urandom_range(0, 160) - 80;
                else if (roll < 90)
                    delta = $urandom_range(0, 131070) - 65535;
                else
                    delta = $urandom;
                send_move(delta);
                counted++;
                repeat ($urandom_range(10, 60))
                begin
                    e = servo_error();
                    toward = (e > 0) ? 1 : (e < 0) ? -1 : (($urandom_range(1) != 0) ? 1 : -1);
                    roll = $urandom_range(99);
                    if (roll < 30)
                        send_tick();
                    else if (roll < 33)
                        step_encoder(2);
                    else if (roll < 36)
                        step_encoder(0);
                    else if (roll < 46)
                        step_encoder(-toward);
                    else
                        step_encoder(toward);
                    counted++;
                end
            end
        end
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              <= 1'b0;
        word_in.valid      <= 1'b0;
        word_in.operation  <= OP_SAMPLE;
        word_in.pin_a      <= 1'b0;
        word_in.pin_b      <= 1'b0;
        word_in.move_delta <= '0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_PROP_GAIN;
        cfg_bus.data       <= '0;
        servo_model_reset();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_quadrature_decode();
        test_move_and_tick();
        test_error_extremes();
        test_integral_clamp();
        test_random_servo(0, 0, SET_TYPICAL, 290);
        test_random_servo(85, 0, SET_ALL_MAX, 290);
        test_random_servo(0, 85, SET_ALL_ZERO, 290);
        test_random_servo(6, 6, SET_TYPICAL, 290);

        // Let any stray result show up before the verdict
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        $display("%0d words sent, %0d results checked, %0d register writes, four pacing phases",
                 words_sent, results_checked, reg_writes);
        $display("covered encoder steps and illegal jumps, retargeted moves,");
        $display("and the error, drive and integral clamps");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("quadrature_pid_position_servo regression: pass");
        else
            $display("quadrature_pid_position_servo regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/qps_pkg.sv
rtl/qps_if.sv
rtl/qps_quad.sv
rtl/qps_pid.sv
rtl/quadrature_pid_position_servo.sv
test/tb.sv
